@@ design/lssp_pkg.sv @@
// Shared types and constants of the link-state shortest path block.
`default_nettype none
package lssp_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  localparam logic [18:0] DIST_SAT = 19'h7FFFF;

  // One stored link-state entry.
  typedef struct packed {
    logic [4:0]  link;
    logic [15:0] cost;
  } entry_t;

  // One cell of the symmetric edge matrix.
  typedef struct packed {
    logic        vld;
    logic [15:0] cost;
  } edge_t;

  // Status from the front part toward the queue.
  typedef struct packed {
    logic busy;
    logic run_push;
  } front_stat_t;

  // One route word as it leaves the block.
  typedef struct packed {
    logic        valid;
    logic [3:0]  destination;
    logic [3:0]  first_hop;
    logic [18:0] path_distance;
    logic        reachable;
    logic        is_local;
    logic        last_route;
  } route_t;

endpackage
`default_nettype wire

@@ design/lssp_ram.sv @@
// Generic single write port RAM with registered read.
`default_nettype none
module lssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

@@ design/lssp_front.sv @@
// Front part: checks each input word, drops duplicates and appends entries to the rows.
`default_nettype none
module lssp_front import lssp_pkg::*; #(
  parameter int NODES            = 8,
  parameter int LINK_IDS         = 16,
  parameter int ENTRIES_PER_NODE = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic accept,
  input  wire logic in_command,
  input  wire logic [3:0] in_origin_router,
  input  wire logic [4:0] in_link_id,
  input  wire logic [15:0] in_link_cost,
  input  wire logic [3:0] own_router,
  input  wire logic back_sel,
  input  wire logic [$clog2(NODES)-1:0] back_row,
  output logic [$clog2(ENTRIES_PER_NODE+1)-1:0] back_cnt,
  output logic ram_we,
  output logic [$clog2(NODES*ENTRIES_PER_NODE)-1:0] ram_waddr,
  output entry_t ram_wdata,
  output logic [$clog2(NODES*ENTRIES_PER_NODE)-1:0] ram_raddr,
  input  entry_t ram_rdata,
  output front_stat_t stat
);
  localparam int NW  = $clog2(NODES);
  localparam int CW  = $clog2(ENTRIES_PER_NODE + 1);
  localparam int EAW = $clog2(NODES * ENTRIES_PER_NODE);

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_SCAN  = 2'd1;
  localparam logic [1:0] F_CHECK = 2'd2;

  logic [1:0]    st_r, st_nxt;
  logic [NW-1:0] row_r, row_nxt;
  logic [CW-1:0] e_r, e_nxt;
  logic [4:0]    link_r, link_nxt;
  logic [15:0]   cost_r, cost_nxt;
  logic [CW-1:0] cnt_r [NODES];

  logic          root_ok, link_ok, origin_ok, full, inc, push;
  logic [NW-1:0] root, in_row, cnt_sel;
  logic [CW-1:0] cnt_cur;

  assign root_ok  = (own_router != 4'd0) && (32'(own_router) <= NODES);
  assign root     = NW'(32'(own_router) - 32'd1);
  assign in_row   = (in_command == CMD_LOAD) ? root : NW'(32'(in_origin_router) - 32'd1);
  assign link_ok  = (in_link_id != 5'd0) && (32'(in_link_id) <= LINK_IDS);
  assign origin_ok = (in_origin_router != 4'd0) && (32'(in_origin_router) <= NODES) &&
                     (in_origin_router != own_router);
  assign cnt_sel  = back_sel ? back_row : ((st_r == F_IDLE) ? in_row : row_r);
  assign cnt_cur  = cnt_r[cnt_sel];
  assign back_cnt = cnt_cur;
  assign full     = 32'(cnt_cur) >= ENTRIES_PER_NODE;
  assign ram_waddr = EAW'(32'(cnt_sel) * ENTRIES_PER_NODE + 32'(cnt_cur));
  assign ram_raddr = EAW'(32'(row_r) * ENTRIES_PER_NODE + 32'(e_r));

  always_comb begin
    st_nxt    = st_r;
    row_nxt   = row_r;
    e_nxt     = e_r;
    link_nxt  = link_r;
    cost_nxt  = cost_r;
    inc       = 1'b0;
    push      = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = '{link: link_r, cost: cost_r};
    case (st_r)
      F_IDLE: begin
        if (accept && link_ok) begin
          if (in_command == CMD_LOAD) begin
            if (root_ok && !full) begin
              ram_we    = 1'b1;
              ram_wdata = '{link: in_link_id, cost: in_link_cost};
              inc       = 1'b1;
            end
          end else if (origin_ok) begin
            row_nxt  = in_row;
            link_nxt = in_link_id;
            cost_nxt = in_link_cost;
            e_nxt    = '0;
            st_nxt   = F_SCAN;
          end
        end
      end
      F_SCAN: begin
        if (e_r == cnt_cur) begin
          if (!full) begin
            ram_we = 1'b1;
            inc    = 1'b1;
            push   = 1'b1;
          end
          st_nxt = F_IDLE;
        end else begin
          st_nxt = F_CHECK;
        end
      end
      F_CHECK: begin
        if (ram_rdata.link == link_r && ram_rdata.cost == cost_r) begin
          st_nxt = F_IDLE;
        end else begin
          e_nxt  = e_r + CW'(1);
          st_nxt = F_SCAN;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      for (int n = 0; n < NODES; n++) begin
        cnt_r[n] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (inc) begin
        cnt_r[cnt_sel] <= cnt_cur + CW'(1);
      end
    end
    row_r  <= row_nxt;
    e_r    <= e_nxt;
    link_r <= link_nxt;
    cost_r <= cost_nxt;
  end

  assign stat = '{busy: (st_r != F_IDLE), run_push: push};
endmodule
`default_nettype wire

@@ design/lssp_back.sv @@
// Back part: rebuilds the edge matrix, runs the shortest path search and emits the routes.
`default_nettype none
module lssp_back import lssp_pkg::*; #(
  parameter int NODES            = 8,
  parameter int LINK_IDS         = 16,
  parameter int ENTRIES_PER_NODE = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic run_req,
  output logic run_pop,
  input  wire logic [3:0] own_router,
  output logic back_busy,
  output logic [$clog2(NODES)-1:0] back_row,
  input  wire logic [$clog2(ENTRIES_PER_NODE+1)-1:0] back_cnt,
  output logic [$clog2(NODES*ENTRIES_PER_NODE)-1:0] ent_raddr,
  input  entry_t ent_rdata,
  output route_t route
);
  localparam int NW  = $clog2(NODES);
  localparam int LW  = $clog2(LINK_IDS);
  localparam int CW  = $clog2(ENTRIES_PER_NODE + 1);
  localparam int KW  = $clog2(NODES + 1);
  localparam int DW  = 16 + $clog2(NODES);
  localparam int EAW = $clog2(NODES * ENTRIES_PER_NODE);
  localparam int GAW = $clog2(NODES * NODES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_BRD  = 4'd2;
  localparam logic [3:0] S_BENT = 4'd3;
  localparam logic [3:0] S_BFE  = 4'd4;
  localparam logic [3:0] S_BFE2 = 4'd5;
  localparam logic [3:0] S_IRD  = 4'd6;
  localparam logic [3:0] S_IWR  = 4'd7;
  localparam logic [3:0] S_SEL  = 4'd8;
  localparam logic [3:0] S_RRD  = 4'd9;
  localparam logic [3:0] S_RWR  = 4'd10;
  localparam logic [3:0] S_EST  = 4'd11;
  localparam logic [3:0] S_EWK  = 4'd12;

  logic [3:0]     st_r;
  logic [NW-1:0]  i_r, r_r, t_r, next_r, cur_r, prev_r;
  logic [CW-1:0]  e_r;
  logic [GAW-1:0] clr_r;
  logic [KW-1:0]  k_r;
  logic [15:0]    ecost_r;
  logic           found_r;
  logic [DW-1:0]  least_r, dnext_r;
  logic           ev_r   [LINK_IDS];
  logic [DW-1:0]  dist_r [NODES];
  logic           reach_r[NODES];
  logic [NW-1:0]  pred_r [NODES];
  logic           has_r  [NODES];
  logic           sett_r [NODES];
  route_t         route_r;

  logic           root_ok, i_last, r_last, cand, f_n;
  logic [NW-1:0]  root, nx_n, id_pred;
  logic [DW-1:0]  l_n, alt;
  logic [LW-1:0]  id;
  logic           g_we, fe_we;
  logic [GAW-1:0] g_waddr, g_raddr;
  edge_t          g_wdata, g_rdata;
  logic [NW-1:0]  fe_rdata;
  logic           emit;
  logic [3:0]     em_hop;
  logic [DW-1:0]  em_dist;
  logic           em_ok, em_loc;

  assign root_ok = (own_router != 4'd0) && (32'(own_router) <= NODES);
  assign root    = NW'(32'(own_router) - 32'd1);
  assign i_last  = (i_r == NW'(NODES - 1));
  assign r_last  = (r_r == NW'(NODES - 1));
  assign id      = LW'(32'(ent_rdata.link) - 32'd1);
  assign id_pred = pred_r[cur_r];

  assign back_row  = r_r;
  assign back_busy = (st_r != S_IDLE);
  assign run_pop   = (st_r == S_IDLE) && run_req;
  assign ent_raddr = EAW'(32'(r_r) * ENTRIES_PER_NODE + 32'(e_r));

  // Minimum search: on ties the later (higher) index wins.
  assign cand = !sett_r[i_r] && reach_r[i_r] && (!found_r || dist_r[i_r] <= least_r);
  assign f_n  = found_r || cand;
  assign nx_n = cand ? i_r : next_r;
  assign l_n  = cand ? dist_r[i_r] : least_r;
  assign alt  = dnext_r + DW'(g_rdata.cost);

  lssp_ram #(.WIDTH(NW), .DEPTH(LINK_IDS)) u_first_end (
    .clk(clk), .we(fe_we), .waddr(id), .wdata(r_r), .raddr(id), .rdata(fe_rdata)
  );

  lssp_ram #(.WIDTH($bits(edge_t)), .DEPTH(NODES * NODES)) u_edges (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
  );

  always_comb begin
    g_we    = 1'b0;
    g_waddr = clr_r;
    g_wdata = '0;
    fe_we   = 1'b0;
    g_raddr = GAW'(32'(i_r) * NODES + 32'(next_r));
    case (st_r)
      S_CLR: g_we = 1'b1;
      S_BENT: fe_we = !ev_r[id];
      S_BFE: begin
        g_we    = 1'b1;
        g_waddr = GAW'(32'(r_r) * NODES + 32'(fe_rdata));
        g_wdata = '{vld: 1'b1, cost: ecost_r};
      end
      S_BFE2: begin
        g_we    = 1'b1;
        g_waddr = GAW'(32'(t_r) * NODES + 32'(r_r));
        g_wdata = '{vld: 1'b1, cost: ecost_r};
      end
      S_IRD: g_raddr = GAW'(32'(root) * NODES + 32'(i_r));
      default: ;
    endcase
  end

  // Route word for the current destination.
  always_comb begin
    emit    = 1'b0;
    em_hop  = 4'd0;
    em_dist = '0;
    em_ok   = 1'b0;
    em_loc  = 1'b0;
    if (st_r == S_EST) begin
      if (root_ok && i_r == root) begin
        emit   = 1'b1;
        em_ok  = 1'b1;
        em_loc = 1'b1;
      end else if (!(root_ok && reach_r[i_r])) begin
        emit = 1'b1;
      end
    end else if (st_r == S_EWK) begin
      if (32'(k_r) == NODES || !has_r[cur_r] || id_pred == root) begin
        emit    = 1'b1;
        em_hop  = 4'(32'(prev_r) + 32'd1);
        em_dist = dist_r[i_r];
        em_ok   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_IDLE;
      route_r.valid <= 1'b0;
      for (int n = 0; n < NODES; n++) begin
        sett_r[n] <= 1'b0;
      end
    end else begin
      route_r.valid <= emit;
      case (st_r)
        S_IDLE: begin
          if (run_req) begin
            clr_r <= '0;
            for (int n = 0; n < LINK_IDS; n++) begin
              ev_r[n] <= 1'b0;
            end
            st_r <= root_ok ? S_CLR : S_EST;
            i_r  <= '0;
          end
        end
        S_CLR: begin
          clr_r <= clr_r + GAW'(1);
          if (32'(clr_r) == NODES * NODES - 1) begin
            r_r  <= '0;
            e_r  <= '0;
            st_r <= S_BRD;
          end
        end
        S_BRD: begin
          if (e_r == back_cnt) begin
            e_r <= '0;
            if (r_last) begin
              i_r  <= '0;
              st_r <= S_IRD;
            end else begin
              r_r <= r_r + NW'(1);
            end
          end else begin
            st_r <= S_BENT;
          end
        end
        S_BENT: begin
          ecost_r <= ent_rdata.cost;
          if (ev_r[id]) begin
            st_r <= S_BFE;
          end else begin
            ev_r[id] <= 1'b1;
            e_r      <= e_r + CW'(1);
            st_r     <= S_BRD;
          end
        end
        S_BFE: begin
          t_r  <= fe_rdata;
          st_r <= S_BFE2;
        end
        S_BFE2: begin
          e_r  <= e_r + CW'(1);
          st_r <= S_BRD;
        end
        S_IRD: st_r <= S_IWR;
        S_IWR: begin
          sett_r[i_r]  <= 1'b0;
          reach_r[i_r] <= g_rdata.vld || (i_r == root);
          has_r[i_r]   <= g_rdata.vld;
          pred_r[i_r]  <= g_rdata.vld ? root : '0;
          dist_r[i_r]  <= (g_rdata.vld && i_r != root) ? DW'(g_rdata.cost) : '0;
          if (i_last) begin
            i_r     <= '0;
            found_r <= 1'b0;
            st_r    <= S_SEL;
          end else begin
            i_r  <= i_r + NW'(1);
            st_r <= S_IRD;
          end
        end
        S_SEL: begin
          found_r <= f_n;
          next_r  <= nx_n;
          least_r <= l_n;
          i_r     <= i_last ? '0 : i_r + NW'(1);
          if (i_last) begin
            if (f_n) begin
              sett_r[nx_n] <= 1'b1;
              dnext_r      <= l_n;
              st_r         <= S_RRD;
            end else begin
              st_r <= S_EST;
            end
          end
        end
        S_RRD: st_r <= S_RWR;
        S_RWR: begin
          if (g_rdata.vld && !sett_r[i_r] && (!reach_r[i_r] || alt < dist_r[i_r])) begin
            dist_r[i_r]  <= alt;
            reach_r[i_r] <= 1'b1;
            pred_r[i_r]  <= next_r;
            has_r[i_r]   <= 1'b1;
          end
          if (i_last) begin
            i_r     <= '0;
            found_r <= 1'b0;
            st_r    <= S_SEL;
          end else begin
            i_r  <= i_r + NW'(1);
            st_r <= S_RRD;
          end
        end
        S_EST, S_EWK: begin
          if (emit) begin
            st_r <= i_last ? S_IDLE : S_EST;
            i_r  <= i_r + NW'(1);
          end else if (st_r == S_EST) begin
            cur_r  <= i_r;
            prev_r <= i_r;
            k_r    <= '0;
            st_r   <= S_EWK;
          end else begin
            cur_r  <= id_pred;
            prev_r <= id_pred;
            k_r    <= k_r + KW'(1);
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
    route_r.destination   <= 4'(32'(i_r) + 32'd1);
    route_r.first_hop     <= em_hop;
    route_r.path_distance <= (32'(em_dist) > 32'(DIST_SAT)) ? DIST_SAT : 19'(em_dist);
    route_r.reachable     <= em_ok;
    route_r.is_local      <= em_loc;
    route_r.last_route    <= i_last;
  end

  assign route = route_r;
endmodule
`default_nettype wire

@@ design/link_state_shortest_path_top.sv @@
// Top level of the link-state shortest path block: front, run queue, entry table and back.
//
//  channel   ports                                         handshake
//  input     in_command, in_origin_router, in_link_id,     start / busy
//            in_link_cost
//  result    out_destination, out_first_hop,               out_valid strobe
//            out_path_distance, out_reachable,
//            out_is_local, out_last_route
//  config    cfg_wdata (own_router)                        cfg_we
//
// A load word or a dropped word is handled straight from idle; a received word is compared
// in the front against each entry already in its row and, if new and its row has room, is
// stored with a run request. A run then clears the edge matrix, rebuilds it from the stored
// entries, seeds the distances from the root, runs the search rounds and emits one route per
// destination. The edge and entry tables have one write and one registered read port each.
// Reset clears the row counts, the queue and all state machines; no clearing pass is needed.
// busy falls in the same cycle as the last route word is shown on the outputs; results cannot be held off.
`default_nettype none
module link_state_shortest_path_top import lssp_pkg::*; #(
  parameter int NODES            = 8,
  parameter int LINK_IDS         = 16,
  parameter int ENTRIES_PER_NODE = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [3:0]  in_origin_router,
  input  wire logic [4:0]  in_link_id,
  input  wire logic [15:0] in_link_cost,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  output logic             out_valid,
  output logic [3:0]       out_destination,
  output logic [3:0]       out_first_hop,
  output logic [18:0]      out_path_distance,
  output logic             out_reachable,
  output logic             out_is_local,
  output logic             out_last_route
);
  localparam int NW  = $clog2(NODES);
  localparam int CW  = $clog2(ENTRIES_PER_NODE + 1);
  localparam int EAW = $clog2(NODES * ENTRIES_PER_NODE);

  logic [3:0]     own_r;
  logic [1:0]     q_cnt_r, q_cnt_nxt;
  front_stat_t    fstat;
  logic           run_pop, back_busy, ent_we;
  logic [NW-1:0]  back_row;
  logic [CW-1:0]  back_cnt;
  logic [EAW-1:0] ent_waddr, f_raddr, b_raddr;
  entry_t         ent_wdata, ent_rdata;
  route_t         route;

  assign busy      = fstat.busy || (q_cnt_r != 2'd0) || back_busy;
  assign q_cnt_nxt = q_cnt_r + 2'(fstat.run_push) - 2'(run_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= 4'd1;
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (cfg_we) begin
        own_r <= cfg_wdata;
      end
    end
  end

  lssp_front #(
    .NODES(NODES), .LINK_IDS(LINK_IDS), .ENTRIES_PER_NODE(ENTRIES_PER_NODE)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .accept(start && !busy),
    .in_command(in_command), .in_origin_router(in_origin_router),
    .in_link_id(in_link_id), .in_link_cost(in_link_cost), .own_router(own_r),
    .back_sel(back_busy), .back_row(back_row), .back_cnt(back_cnt),
    .ram_we(ent_we), .ram_waddr(ent_waddr), .ram_wdata(ent_wdata),
    .ram_raddr(f_raddr), .ram_rdata(ent_rdata), .stat(fstat)
  );

  lssp_ram #(.WIDTH($bits(entry_t)), .DEPTH(NODES * ENTRIES_PER_NODE)) u_entries (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(back_busy ? b_raddr : f_raddr), .rdata(ent_rdata)
  );

  lssp_back #(
    .NODES(NODES), .LINK_IDS(LINK_IDS), .ENTRIES_PER_NODE(ENTRIES_PER_NODE)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .run_req(q_cnt_r != 2'd0), .run_pop(run_pop),
    .own_router(own_r), .back_busy(back_busy), .back_row(back_row), .back_cnt(back_cnt),
    .ent_raddr(b_raddr), .ent_rdata(ent_rdata), .route(route)
  );

  assign out_valid         = route.valid;
  assign out_destination   = route.destination;
  assign out_first_hop     = route.first_hop;
  assign out_path_distance = route.path_distance;
  assign out_reachable     = route.reachable;
  assign out_is_local      = route.is_local;
  assign out_last_route    = route.last_route;

  // Only one run can be pending since the front is blocked while one is outstanding.
  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r < 2'd2)
    else $error("run queue overflow");
  a_front_idle: assert property (@(posedge clk) disable iff (!rst_n)
    back_busy |-> !fstat.busy)
    else $error("front active during a run");
  a_pop_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
    run_pop |-> q_cnt_r != 2'd0)
    else $error("run started without a request");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_route |=> !out_valid)
    else $error("route word after the last one");
endmodule
`default_nettype wire
